[rtl/rclbs_pkg.sv]
package rclbs_pkg;

	// stick scaling
	localparam int CHANNEL_FULL_SCALE = 10000;
	localparam int MAG_W = $clog2(CHANNEL_FULL_SCALE + 1);
	localparam int NUM_W = $clog2(CHANNEL_FULL_SCALE * 255 + 1);
	localparam int QUO_W = 8;
	localparam int CH_W = 16;

	// reciprocal of full scale, rounded up; the shift keeps the quotient exact
	// for every numerator up to 255 times full scale
	localparam int     RECIP_SHIFT = NUM_W + MAG_W;
	localparam longint RECIP_MUL = ((longint'(1) << RECIP_SHIFT)
		+ longint'(CHANNEL_FULL_SCALE) - longint'(1)) / longint'(CHANNEL_FULL_SCALE);
	localparam int     RECIP_W = $clog2(RECIP_MUL + 1);
	localparam int     PROD_W = NUM_W + RECIP_W;

	localparam int NUM_LANES = 4;
	localparam int LANE_THR = 0;
	localparam int LANE_RUD = 1;
	localparam int LANE_ELE = 2;
	localparam int LANE_AIL = 3;

	// bind sequencing
	localparam int BIND_REPEATS = 60;
	localparam int CNT_W = 6;

	// step queue, depth is a power of two so the pointers wrap
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// payload
	localparam int PKT_BYTES = 8;
	localparam int PIDX_W = $clog2(PKT_BYTES);
	localparam int IDX_W = PIDX_W + 1;

	localparam logic [2:0] VAR_BASE = 3'd0;
	localparam logic [2:0] VAR_SWAP_RUD = 3'd2;
	localparam logic [2:0] VAR_ZERO_BIND = 3'd3;
	localparam logic [2:0] VAR_X4 = 3'd4;

	localparam logic [7:0] BIND_ADDR_X4 = 8'h60;
	localparam logic [7:0] BIND_ADDR_ZERO = 8'h64;
	localparam logic [7:0] BIND_ADDR_STD = 8'h65;
	localparam logic [7:0] BIND_MAGIC0 = 8'h56;
	localparam logic [7:0] BIND_MAGIC1 = 8'hAA;
	localparam logic [7:0] BIND_OPT = 8'h32;
	localparam logic [7:0] FLAG_FLIP = 8'h0F;
	localparam logic [7:0] FLAG_LIGHT = 8'h10;
	localparam logic [7:0] BYTE_MAX = 8'hFF;
	localparam logic [8:0] SCALE_OFFSET = 9'h100;

	// register word index (paddr[2])
	localparam logic REG_VARIANT = 1'b0;
	localparam logic REG_DATA_ADDR = 1'b1;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_BIND_ADDR,
		KIND_DATA_ADDR,
		KIND_END
	} kind_t;

	typedef enum logic [1:0] {
		PH_INIT,
		PH_BIND,
		PH_CHECK,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		SW_NONE,
		SW_BIND,
		SW_DATA
	} sw_t;

	typedef enum logic [1:0] {
		PAY_NONE,
		PAY_DATA,
		PAY_BIND
	} pay_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SWITCH,
		BK_PAYLOAD,
		BK_END
	} back_state_t;

	typedef struct packed {
		sw_t        sw;
		logic [7:0] sw_byte;
		pay_t       pay;
		logic       long_wait;
	} step_ctl_t;

	typedef struct packed {
		logic             neg;
		logic [NUM_W-1:0] num;
	} lane_t;

	typedef struct packed {
		step_ctl_t                 ctl;
		logic                      flip;
		logic                      light;
		lane_t [NUM_LANES-1:0]     lane;
	} front_out_t;

	typedef struct packed {
		sw_t                       sw;
		logic [7:0]                sw_byte;
		logic                      has_pay;
		logic                      with_sum;
		logic [PKT_BYTES-1:0][7:0] pkt;
		logic                      long_wait;
	} step_desc_t;

	// ((+-quo) + 256) >> 1
	function automatic logic [7:0] scale_byte(input logic neg, input logic [QUO_W-1:0] quo);
		logic [8:0] q9;
		if (neg) begin
			q9 = SCALE_OFFSET - {1'b0, quo};
		end else begin
			q9 = SCALE_OFFSET + {1'b0, quo};
		end
		return q9[8:1];
	endfunction

endpackage

[rtl/rclbs_front.sv]
module rclbs_front import rclbs_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          sent_flag,
	input  logic                          retry_flag,
	input  logic [NUM_LANES-1:0][CH_W-1:0] ch,
	input  logic                          flip_on,
	input  logic                          light_on,
	input  logic [2:0]                    variant,
	input  logic                          pop,
	output logic                          valid_s1,
	output front_out_t                    out_s1
);

	localparam logic signed [CH_W-1:0] FS_POS = CH_W'(CHANNEL_FULL_SCALE);
	localparam logic signed [CH_W-1:0] FS_NEG = -FS_POS;

	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  bind_cnt_q, bind_cnt_d;
	logic [QCNT_W-1:0] reserved_q;
	logic              accept;
	logic              acked, timeout, pending;
	logic [7:0]        bind_byte;
	step_ctl_t         ctl_d;
	lane_t [NUM_LANES-1:0] lane_d;

	assign in_ready = reserved_q < QCNT_W'(QUEUE_DEPTH);
	assign accept   = in_valid & in_ready;

	assign acked   = sent_flag & ~retry_flag;
	assign timeout = retry_flag & ~sent_flag;
	assign pending = ~acked & ~timeout;

	always_comb begin
		priority if (variant == VAR_X4) begin
			bind_byte = BIND_ADDR_X4;
		end else if (variant == VAR_ZERO_BIND) begin
			bind_byte = BIND_ADDR_ZERO;
		end else begin
			bind_byte = BIND_ADDR_STD;
		end
	end

	// phase machine: next state
	always_comb begin
		phase_d    = phase_q;
		bind_cnt_d = bind_cnt_q;
		unique case (phase_q)
			PH_INIT: begin
				phase_d = PH_CHECK;
			end
			PH_BIND: begin
				if (!pending) begin
					if (bind_cnt_q == '0) begin
						phase_d = PH_CHECK;
					end else begin
						bind_cnt_d = bind_cnt_q - CNT_W'(1);
					end
				end
			end
			PH_CHECK: begin
				if (acked) begin
					phase_d = PH_DATA;
				end else if (timeout) begin
					phase_d    = PH_BIND;
					bind_cnt_d = CNT_W'(BIND_REPEATS);
				end
			end
			PH_DATA: begin
			end
		endcase
	end

	// phase machine: step actions
	always_comb begin
		ctl_d.sw        = SW_NONE;
		ctl_d.sw_byte   = '0;
		ctl_d.pay       = PAY_NONE;
		ctl_d.long_wait = 1'b1;
		unique case (phase_q)
			PH_INIT: begin
				ctl_d.pay = PAY_DATA;
			end
			PH_BIND: begin
				if (pending) begin
					ctl_d.long_wait = 1'b0;
				end else if (bind_cnt_q == '0) begin
					ctl_d.sw  = SW_DATA;
					ctl_d.pay = PAY_DATA;
				end else begin
					ctl_d.pay = PAY_BIND;
				end
			end
			PH_CHECK: begin
				if (pending) begin
					ctl_d.long_wait = 1'b0;
				end else if (timeout) begin
					ctl_d.sw      = SW_BIND;
					ctl_d.sw_byte = bind_byte;
					ctl_d.pay     = PAY_BIND;
				end
			end
			PH_DATA: begin
				if (pending) begin
					ctl_d.long_wait = 1'b0;
				end else begin
					ctl_d.pay = PAY_DATA;
				end
			end
		endcase
	end

	// clamp, magnitude and times 255 per stick
	always_comb begin
		logic signed [CH_W-1:0] c;
		logic [CH_W-1:0]        mag16;
		logic [MAG_W-1:0]       mag;
		for (int i = 0; i < NUM_LANES; i++) begin
			c = $signed(ch[i]);
			if (c > FS_POS) begin
				c = FS_POS;
			end else if (c < FS_NEG) begin
				c = FS_NEG;
			end
			mag16 = c[CH_W-1] ? CH_W'(-c) : CH_W'(c);
			mag   = mag16[MAG_W-1:0];
			lane_d[i].neg = c[CH_W-1];
			lane_d[i].num = (NUM_W'(mag) << 8) - NUM_W'(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_INIT;
			bind_cnt_q <= '0;
			reserved_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				phase_q    <= phase_d;
				bind_cnt_q <= bind_cnt_d;
			end
			unique case ({accept, pop})
				2'b10:   reserved_q <= reserved_q + QCNT_W'(1);
				2'b01:   reserved_q <= reserved_q - QCNT_W'(1);
				default: reserved_q <= reserved_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_s1.ctl   <= ctl_d;
			out_s1.flip  <= flip_on;
			out_s1.light <= light_on;
			out_s1.lane  <= lane_d;
		end
	end

`ifndef ASSERT_OFF
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		reserved_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("step credits exceed queue depth");

	a_bind_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_BIND && !pending && bind_cnt_q != '0
		|=> bind_cnt_q == $past(bind_cnt_q) - CNT_W'(1))
		else $error("bind count did not step down");

	a_init_exit: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_INIT |=> phase_q == PH_CHECK)
		else $error("init phase did not move to bind check");
`endif

endmodule

[rtl/rclbs_scale.sv]
module rclbs_scale import rclbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  front_out_t  in_s1,
	input  logic [2:0]  variant,
	input  logic [31:0] data_address,
	output logic        push,
	output step_desc_t  desc
);

	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_MUL);

	logic             v_s2;
	step_ctl_t        ctl_s2;
	logic             flip_s2;
	logic             light_s2;
	logic             neg_s2 [NUM_LANES];
	logic [QUO_W-1:0] quo_s2 [NUM_LANES];
	logic [QUO_W-1:0] quo_d  [NUM_LANES];

	// divide by full scale as a reciprocal multiply, all four sticks side by side
	always_comb begin
		logic [PROD_W-1:0] prod;
		for (int l = 0; l < NUM_LANES; l++) begin
			prod     = PROD_W'(in_s1.lane[l].num) * PROD_W'(RECIP);
			quo_d[l] = prod[RECIP_SHIFT +: QUO_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2   <= in_s1.ctl;
		flip_s2  <= in_s1.flip;
		light_s2 <= in_s1.light;
		for (int l = 0; l < NUM_LANES; l++) begin
			neg_s2[l] <= in_s1.lane[l].neg;
			quo_s2[l] <= quo_d[l];
		end
	end

	// packet assembly
	always_comb begin
		logic [7:0] sc [NUM_LANES];
		logic [7:0] rud, rtrim, ele, etrim, ail, atrim, flags;
		step_ctl_t  ctl;
		ctl = ctl_s2;
		for (int l = 0; l < NUM_LANES; l++) begin
			sc[l] = scale_byte(neg_s2[l], quo_s2[l]);
		end
		if (variant == VAR_SWAP_RUD) begin
			rud   = sc[LANE_RUD];
			rtrim = (BYTE_MAX - rud) >> 1;
		end else begin
			rud   = BYTE_MAX - sc[LANE_RUD];
			rtrim = rud >> 1;
		end
		ele   = sc[LANE_ELE];
		etrim = ele >> 1;
		ail   = BYTE_MAX - sc[LANE_AIL];
		atrim = ail >> 1;
		flags = (flip_s2 ? FLAG_FLIP : 8'h00) | (light_s2 ? FLAG_LIGHT : 8'h00);

		desc.sw        = ctl.sw;
		desc.sw_byte   = ctl.sw_byte;
		desc.has_pay   = ctl.pay != PAY_NONE;
		desc.with_sum  = variant != VAR_BASE;
		desc.long_wait = ctl.long_wait;
		if (ctl.pay == PAY_BIND) begin
			desc.pkt[0] = data_address[7:0];
			desc.pkt[1] = data_address[15:8];
			desc.pkt[2] = data_address[23:16];
			desc.pkt[3] = data_address[31:24];
			desc.pkt[4] = BIND_MAGIC0;
			desc.pkt[5] = BIND_MAGIC1;
			desc.pkt[6] = (variant == VAR_ZERO_BIND) ? 8'h00 : BIND_OPT;
			desc.pkt[7] = 8'h00;
		end else begin
			desc.pkt[0] = sc[LANE_THR];
			desc.pkt[1] = rud;
			desc.pkt[3] = ele;
			desc.pkt[4] = ail;
			desc.pkt[7] = flags;
			if (variant == VAR_BASE) begin
				desc.pkt[6] = rtrim;
				desc.pkt[2] = etrim;
				desc.pkt[5] = atrim;
			end else begin
				desc.pkt[2] = rtrim;
				desc.pkt[5] = etrim;
				desc.pkt[6] = atrim;
			end
		end
	end

	assign push = v_s2;

endmodule

[rtl/rclbs_queue.sv]
module rclbs_queue import rclbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  step_desc_t push_desc,
	input  logic       pop,
	output logic       not_empty,
	output step_desc_t head_desc
);

	step_desc_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              full;

	assign not_empty = count_q != '0;
	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign head_desc = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("step queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("step queue underflow");
`endif

endmodule

[rtl/rclbs_back.sv]
module rclbs_back import rclbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  step_desc_t q_desc,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output kind_t      out_kind,
	output logic [7:0] out_byte,
	output logic       out_long_wait,
	output logic       out_last
);

	back_state_t      state_q, state_d;
	step_desc_t       cur_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic [IDX_W-1:0] last_idx;
	logic [7:0]       cur_byte;
	logic             adv;
	logic             load;
	logic             byte_step;
	kind_t            kind_d;
	logic [7:0]       byte_d;
	logic             lw_d, last_d;
	logic             out_valid_q;

	assign adv      = ~out_valid_q | out_ready;
	assign last_idx = cur_q.with_sum ? IDX_W'(PKT_BYTES) : IDX_W'(PKT_BYTES - 1);
	assign cur_byte = (idx_q == IDX_W'(PKT_BYTES)) ? ~sum_q : cur_q.pkt[idx_q[PIDX_W-1:0]];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					priority if (q_desc.sw != SW_NONE) begin
						state_d = BK_SWITCH;
					end else if (q_desc.has_pay) begin
						state_d = BK_PAYLOAD;
					end else begin
						state_d = BK_END;
					end
				end
			end
			BK_SWITCH: begin
				if (adv) begin
					state_d = cur_q.has_pay ? BK_PAYLOAD : BK_END;
				end
			end
			BK_PAYLOAD: begin
				if (adv && idx_q == last_idx) begin
					state_d = BK_END;
				end
			end
			BK_END: begin
				if (adv) begin
					state_d = BK_IDLE;
				end
			end
		endcase
	end

	// outputs
	always_comb begin
		pop       = 1'b0;
		load      = 1'b0;
		byte_step = 1'b0;
		kind_d    = KIND_BYTE;
		byte_d    = '0;
		lw_d      = 1'b0;
		last_d    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop = q_valid;
			end
			BK_SWITCH: begin
				load   = adv;
				kind_d = (cur_q.sw == SW_BIND) ? KIND_BIND_ADDR : KIND_DATA_ADDR;
				byte_d = cur_q.sw_byte;
			end
			BK_PAYLOAD: begin
				load      = adv;
				byte_step = adv;
				byte_d    = cur_byte;
			end
			BK_END: begin
				load   = adv;
				kind_d = KIND_END;
				lw_d   = cur_q.long_wait;
				last_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_desc;
			idx_q <= '0;
			sum_q <= '0;
		end else if (byte_step) begin
			idx_q <= idx_q + IDX_W'(1);
			sum_q <= sum_q + cur_byte;
		end
		if (load) begin
			out_kind      <= kind_d;
			out_byte      <= byte_d;
			out_long_wait <= lw_d;
			out_last      <= last_d;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last |-> out_kind == KIND_END)
		else $error("last flag on a result other than step end");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_PAYLOAD |-> idx_q <= last_idx)
		else $error("payload index ran past the packet");
`endif

endmodule

[rtl/rc_link_bind_and_packet_sequencer.sv]
// path: a step transaction goes through the input register, the stick reciprocal multiply register,
// the step queue, the back sequencer pop and the output register before its first result shows
// serializer: the back sequencer idles between steps and sends one result per cycle while the
// receiver is ready; up to 4 steps are taken in ahead through the step queue
// reset: phase init, bind count zero, variant 0, data address 0, queue and pipeline empty;
// no clearing pass
module rc_link_bind_and_packet_sequencer import rclbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// step input
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] sent_flag, [1] retry_flag, [17:2] throttle_in, [33:18] rudder_in,
	// [49:34] elevator_in, [65:50] aileron_in, [66] flip_on, [67] light_on, [71:68] zero
	input  logic [71:0] s_tdata,
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] data_byte, [8] long_wait, [15:9] zero
	output logic [15:0] m_tdata,
	// [1:0] kind
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0]  variant_q;
	logic [31:0] data_address_q;
	logic        cfg_write;

	logic [NUM_LANES-1:0][CH_W-1:0] ch;
	logic       valid_s1;
	front_out_t front_s1;
	logic       push;
	step_desc_t push_desc;
	logic       q_valid;
	step_desc_t head_desc;
	logic       pop;
	kind_t      out_kind;
	logic [7:0] out_byte;
	logic       out_long_wait;

	// register port: two words, byte offset within a word ignored
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q      <= '0;
			data_address_q <= '0;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_VARIANT:   variant_q      <= pwdata[2:0];
				REG_DATA_ADDR: data_address_q <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_VARIANT:   prdata = {29'b0, variant_q};
			REG_DATA_ADDR: prdata = data_address_q;
		endcase
	end

	// unpack the stick channels into lanes
	assign ch[LANE_THR] = s_tdata[17:2];
	assign ch[LANE_RUD] = s_tdata[33:18];
	assign ch[LANE_ELE] = s_tdata[49:34];
	assign ch[LANE_AIL] = s_tdata[65:50];

	// front: link phase machine, stick clamp, queue credits
	rclbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.sent_flag  (s_tdata[0]),
		.retry_flag (s_tdata[1]),
		.ch         (ch),
		.flip_on    (s_tdata[66]),
		.light_on   (s_tdata[67]),
		.variant    (variant_q),
		.pop        (pop),
		.valid_s1   (valid_s1),
		.out_s1     (front_s1)
	);

	// stick scaling and packet assembly
	rclbs_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.in_s1        (front_s1),
		.variant      (variant_q),
		.data_address (data_address_q),
		.push         (push),
		.desc         (push_desc)
	);

	// decouples the step pipeline from the serializer
	rclbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.not_empty (q_valid),
		.head_desc (head_desc)
	);

	// back: address switch, payload bytes with checksum in all but the base variant, step end
	rclbs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_desc        (head_desc),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_kind      (out_kind),
		.out_byte      (out_byte),
		.out_long_wait (out_long_wait),
		.out_last      (m_tlast)
	);

	assign m_tdata = {7'b0, out_long_wait, out_byte};
	assign m_tuser = out_kind;

endmodule

[test/rc_link_bind_and_packet_sequencer_tb.sv]
module rc_link_bind_and_packet_sequencer_tb;
	import rclbs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// variant codes the package leaves unnamed
	localparam logic [2:0] VAR_WALKER = 3'd1;
	localparam logic [2:0] VAR_SPARE5 = 3'd5;
	localparam logic [2:0] VAR_SPARE6 = 3'd6;
	localparam logic [2:0] VAR_SPARE7 = 3'd7;

	localparam int RESET_CYCLES = 9;
	// longest quiet stretch: receiver hold-off plus a long sender gap plus pipeline
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AFTER = 150;
	localparam int DATA_STEPS_PER_VARIANT = 5;
	localparam int TAIL_CYCLES = 30;

	typedef enum {
		LINK_PENDING,
		LINK_ACKED,
		LINK_TIMEOUT
	} link_status_t;

	// one step transaction, last field in the low bits of s_tdata
	typedef struct packed {
		logic               light_on;
		logic               flip_on;
		logic signed [15:0] aileron;
		logic signed [15:0] elevator;
		logic signed [15:0] rudder;
		logic signed [15:0] throttle;
		logic               retry;
		logic               sent;
	} step_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic       long_wait;
		logic       last;
	} link_result_t;

	// hand-typed outcome of a directed row, base variant only (no checksum byte)
	typedef struct packed {
		bit        on;
		bit        has_sw;
		bit [7:0]  sw_byte;
		bit        has_pay;
		bit [63:0] pay;
		bit        lw;
	} typed_exp_t;

	localparam typed_exp_t NOT_TYPED = '0;
	localparam typed_exp_t PENDING_END = '{1'b1, 1'b0, 8'h00, 1'b0, 64'h0, 1'b0};
	localparam typed_exp_t ENTER_BIND_ZERO_ADDR =
		'{1'b1, 1'b1, BIND_ADDR_STD, 1'b1, 64'h0032_AA56_0000_0000, 1'b1};
	localparam typed_exp_t BIND_ZERO_ADDR =
		'{1'b1, 1'b0, 8'h00, 1'b1, 64'h0032_AA56_0000_0000, 1'b1};
	localparam typed_exp_t BIND_ONES_ADDR =
		'{1'b1, 1'b0, 8'h00, 1'b1, 64'h0032_AA56_FFFF_FFFF, 1'b1};
	// all sticks at the rails, both flags: thr ff, rud 00, ele 00, ail ff, trims 00/00/7f
	localparam typed_exp_t INIT_RAILS =
		'{1'b1, 1'b0, 8'h00, 1'b1, 64'h1F00_7FFF_0000_00FF, 1'b1};

	typedef struct {
		bit         set_variant;
		logic [2:0] variant;
		bit         set_addr;
		logic [31:0] addr;
		step_item_t step;
		typed_exp_t te;
	} dir_row_t;

	localparam logic [2:0] DATA_VARIANTS [8] = '{VAR_BASE, VAR_SWAP_RUD, VAR_WALKER,
		VAR_ZERO_BIND, VAR_X4, VAR_SPARE5, VAR_SPARE6, VAR_SPARE7};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [0] sent_flag, [1] retry_flag, [17:2] throttle_in, [33:18] rudder_in,
	// [49:34] elevator_in, [65:50] aileron_in, [66] flip_on, [67] light_on, [71:68] zero
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [7:0] data_byte, [8] long_wait, [15:9] zero
	logic [15:0] m_tdata;
	// [1:0] kind
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// link model state and its copy of the registers
	logic [2:0]  link_variant = VAR_BASE;
	logic [31:0] link_data_addr = '0;
	phase_t      link_phase = PH_INIT;
	logic [5:0]  link_bind_left = '0;

	link_result_t step_results[$];
	link_result_t results_due[$];
	dir_row_t     dir_rows[$];

	int  fail_count = 0;
	int  steps_taken = 0;
	int  results_checked = 0;
	int  bind_payloads = 0;
	int  data_payloads = 0;
	int  idle_cycles = 0;
	bit  sender_full_rate = 1'b0;
	bit  hold_off_done = 1'b0;
	logic [7:0] variants_written = '0;

	rc_link_bind_and_packet_sequencer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// link model
	// ---------------------------------------------------------------

	// clamp to full scale, scale to +-255 truncating toward zero, recenter on 128
	function automatic logic [7:0] stick_byte(input logic signed [15:0] raw);
		int ch;
		int q;
		ch = raw;
		if (ch < -CHANNEL_FULL_SCALE) ch = -CHANNEL_FULL_SCALE;
		if (ch > CHANNEL_FULL_SCALE) ch = CHANNEL_FULL_SCALE;
		q = (ch * 255) / CHANNEL_FULL_SCALE + 256;
		return 8'(q >> 1);
	endfunction

	function automatic void note_result(input kind_t kind, input logic [7:0] data_byte,
			input logic long_wait, input logic last);
		link_result_t r;
		r.kind = kind;
		r.data_byte = data_byte;
		r.long_wait = long_wait;
		r.last = last;
		step_results.push_back(r);
	endfunction

	function automatic void emit_payload(input step_item_t it, input bit is_bind);
		logic [7:0] pk [9];
		logic [7:0] rud, rtrim, ele, ail, sum;
		int n;
		if (is_bind) begin
			bind_payloads++;
			for (int i = 0; i < 4; i++) pk[i] = link_data_addr[8*i +: 8];
			pk[4] = BIND_MAGIC0;
			pk[5] = BIND_MAGIC1;
			pk[6] = (link_variant == VAR_ZERO_BIND) ? 8'h00 : BIND_OPT;
			pk[7] = 8'h00;
		end else begin
			data_payloads++;
			// swapped rudder sends the scaled value as is and trims the mirror
			if (link_variant == VAR_SWAP_RUD) begin
				rud = stick_byte(it.rudder);
				rtrim = (BYTE_MAX - rud) >> 1;
			end else begin
				rud = BYTE_MAX - stick_byte(it.rudder);
				rtrim = rud >> 1;
			end
			ele = stick_byte(it.elevator);
			ail = BYTE_MAX - stick_byte(it.aileron);
			pk[0] = stick_byte(it.throttle);
			pk[1] = rud;
			pk[3] = ele;
			pk[4] = ail;
			pk[7] = (it.flip_on ? FLAG_FLIP : 8'h00) | (it.light_on ? FLAG_LIGHT : 8'h00);
			// trim slots move between the base layout and all others
			if (link_variant == VAR_BASE) begin
				pk[6] = rtrim;
				pk[2] = ele >> 1;
				pk[5] = ail >> 1;
			end else begin
				pk[2] = rtrim;
				pk[5] = ele >> 1;
				pk[6] = ail >> 1;
			end
		end
		n = 8;
		if (link_variant != VAR_BASE) begin
			sum = 8'h00;
			for (int i = 0; i < 8; i++) sum = sum + pk[i];
			pk[8] = ~sum;
			n = 9;
		end
		for (int i = 0; i < n; i++) note_result(KIND_BYTE, pk[i], 1'b0, 1'b0);
	endfunction

	function automatic void predict_step(input step_item_t it);
		link_status_t st;
		logic lw;
		st = LINK_PENDING;
		if (it.sent && !it.retry) st = LINK_ACKED;
		else if (it.retry && !it.sent) st = LINK_TIMEOUT;
		lw = 1'b1;
		step_results.delete();
		case (link_phase)
			PH_INIT: begin
				// first packet goes out without looking at the radio
				emit_payload(it, 1'b0);
				link_phase = PH_CHECK;
			end
			PH_BIND: begin
				if (st == LINK_PENDING) begin
					lw = 1'b0;
				end else if (link_bind_left == 0) begin
					note_result(KIND_DATA_ADDR, 8'h00, 1'b0, 1'b0);
					emit_payload(it, 1'b0);
					link_phase = PH_CHECK;
				end else begin
					emit_payload(it, 1'b1);
					link_bind_left = link_bind_left - 1'b1;
				end
			end
			PH_CHECK: begin
				if (st == LINK_PENDING) begin
					lw = 1'b0;
				end else if (st == LINK_ACKED) begin
					link_phase = PH_DATA;
				end else begin
					note_result(KIND_BIND_ADDR,
						(link_variant == VAR_X4) ? BIND_ADDR_X4 :
						(link_variant == VAR_ZERO_BIND) ? BIND_ADDR_ZERO : BIND_ADDR_STD,
						1'b0, 1'b0);
					link_bind_left = 6'(BIND_REPEATS);
					link_phase = PH_BIND;
					emit_payload(it, 1'b1);
				end
			end
			default: begin
				if (st == LINK_PENDING) lw = 1'b0;
				else emit_payload(it, 1'b0);
			end
		endcase
		note_result(KIND_END, 8'h00, lw, 1'b1);
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// rails, full scale and just past it, the truncation edge near zero, or anything
	function automatic logic signed [15:0] pick_stick();
		int v;
		case ($urandom_range(0, 9))
			0: v = 32767;
			1: v = -32768;
			2: v = CHANNEL_FULL_SCALE;
			3: v = -CHANNEL_FULL_SCALE;
			4: v = $urandom_range(0, 1) ? CHANNEL_FULL_SCALE + 1 : -CHANNEL_FULL_SCALE - 1;
			5: v = int'($urandom_range(0, 80)) - 40;
			default: v = int'($urandom_range(0, 65535));
		endcase
		return 16'(v);
	endfunction

	function automatic step_item_t mk_step(input logic sent, input logic retry,
			input logic signed [15:0] thr, input logic signed [15:0] rud,
			input logic signed [15:0] ele, input logic signed [15:0] ail,
			input logic flip, input logic light);
		step_item_t it;
		it.sent = sent;
		it.retry = retry;
		it.throttle = thr;
		it.rudder = rud;
		it.elevator = ele;
		it.aileron = ail;
		it.flip_on = flip;
		it.light_on = light;
		return it;
	endfunction

	// radio status shaped by the link phase: the check phase never sees an ack here,
	// so bind rounds come back; a share of steps stays pending as noise
	function automatic step_item_t random_step();
		int r;
		logic sent, retry;
		r = $urandom_range(0, 99);
		if (link_phase == PH_CHECK) begin
			sent = (r >= 90);
			retry = (r < 80) || (r >= 90);
		end else if (r < 40) begin
			sent = 1'b1;
			retry = 1'b0;
		end else if (r < 85) begin
			sent = 1'b0;
			retry = 1'b1;
		end else begin
			sent = (r >= 93);
			retry = (r >= 93);
		end
		return mk_step(sent, retry, pick_stick(), pick_stick(), pick_stick(), pick_stick(),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endfunction

	// mostly short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	// offer one step, wait for the transaction, record what it must produce
	task automatic send_step(input step_item_t it, input typed_exp_t te);
		int gap;
		s_tdata <= {4'b0000, it};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		steps_taken++;
		predict_step(it);
		if (te.on) begin
			// directed row: replace the model's output with the hand-typed one
			step_results.delete();
			if (te.has_sw) note_result(KIND_BIND_ADDR, te.sw_byte, 1'b0, 1'b0);
			if (te.has_pay) begin
				for (int i = 0; i < 8; i++) note_result(KIND_BYTE, te.pay[8*i +: 8], 1'b0, 1'b0);
			end
			note_result(KIND_END, 8'h00, te.lw, 1'b1);
		end
		foreach (step_results[i]) results_due.push_back(step_results[i]);
		gap = sender_full_rate ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and let every outstanding result drain
	task automatic drain();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write, then read back
	task automatic cfg_write(input logic which, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (which == REG_VARIANT) begin
			link_variant = value[2:0];
			variants_written[value[2:0]] = 1'b1;
		end else begin
			link_data_addr = value;
		end
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (which == REG_VARIANT && prdata[2:0] !== value[2:0]) begin
			$error("variant readback: expected %0d, got %0d", value[2:0], prdata[2:0]);
			fail_count++;
		end else if (which == REG_DATA_ADDR && prdata !== value) begin
			$error("data_address readback: expected %08h, got %08h", value, prdata);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// run until the link has been through bind and is back in bind-check
	task automatic bind_round(input logic [2:0] variant, input logic [31:0] addr);
		bit left_check;
		drain();
		cfg_write(REG_VARIANT, {29'd0, variant});
		cfg_write(REG_DATA_ADDR, addr);
		left_check = (link_phase != PH_CHECK);
		while (!(left_check && link_phase == PH_CHECK)) begin
			send_step(random_step(), NOT_TYPED);
			if (link_phase != PH_CHECK) left_check = 1'b1;
		end
	endtask

	// ---------------------------------------------------------------
	// result checker
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		link_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (results_due.size() == 0) begin
				$error("unexpected result: kind %0d byte %02h", m_tuser, m_tdata[7:0]);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				if (m_tuser !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, m_tuser);
					fail_count++;
				end
				if (m_tdata[7:0] !== want.data_byte) begin
					$error("data_byte: expected %02h, got %02h", want.data_byte, m_tdata[7:0]);
					fail_count++;
				end
				if (m_tdata[8] !== want.long_wait) begin
					$error("long_wait: expected %0d, got %0d", want.long_wait, m_tdata[8]);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog: any transaction on either stream or the register port counts as progress
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("rc_link_bind_and_packet_sequencer_tb NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// receiver: ready in runs, short stalls mostly, and one long hold-off
	// while the sender keeps offering so the step queue fills and s_tready drops
	// ---------------------------------------------------------------
	initial begin
		int run_len;
		int stall_len;
		forever begin
			@(posedge clk);
			if (!hold_off_done && results_checked >= HOLD_OFF_AFTER) begin
				hold_off_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
			m_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) :
				$urandom_range(0, 3);
			if (stall_len > 0) begin
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		// directed table, reset values first: variant base, data address zero
		// init with every stick on its rail and both flags set
		dir_rows.push_back('{0, VAR_BASE, 0, 32'h0,
			mk_step(0, 0, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 1, 1), INIT_RAILS});
		// bind-check: neither flag, then both flags, stay pending
		dir_rows.push_back('{0, VAR_BASE, 0, 32'h0,
			mk_step(0, 0, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 0, 1),
			PENDING_END});
		dir_rows.push_back('{0, VAR_BASE, 0, 32'h0,
			mk_step(1, 1, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 1, 0),
			PENDING_END});
		// timeout: switch to the bind address and start binding
		dir_rows.push_back('{0, VAR_BASE, 0, 32'h0,
			mk_step(0, 1, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 0, 0),
			ENTER_BIND_ZERO_ADDR});
		// bind: pending holds, ack and timeout both advance
		dir_rows.push_back('{0, VAR_BASE, 0, 32'h0,
			mk_step(1, 1, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 1, 1),
			PENDING_END});
		dir_rows.push_back('{0, VAR_BASE, 0, 32'h0,
			mk_step(1, 0, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 0, 0),
			BIND_ZERO_ADDR});
		dir_rows.push_back('{0, VAR_BASE, 0, 32'h0,
			mk_step(0, 1, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 1, 1),
			BIND_ZERO_ADDR});
		// all-ones data address
		dir_rows.push_back('{0, VAR_BASE, 1, 32'hFFFF_FFFF,
			mk_step(1, 0, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 0, 1),
			BIND_ONES_ADDR});
		// variants change mid-bind: zero-bind byte, unused code, x4, checksums
		dir_rows.push_back('{1, VAR_ZERO_BIND, 0, 32'h0,
			mk_step(1, 0, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 1, 0),
			NOT_TYPED});
		dir_rows.push_back('{1, VAR_SPARE7, 1, 32'hA5C3_0F81,
			mk_step(0, 1, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 0, 0),
			NOT_TYPED});
		dir_rows.push_back('{1, VAR_X4, 0, 32'h0,
			mk_step(1, 0, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 1, 1),
			NOT_TYPED});
		dir_rows.push_back('{1, VAR_SWAP_RUD, 0, 32'h0,
			mk_step(0, 0, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 0, 1),
			PENDING_END});
		dir_rows.push_back('{1, VAR_SPARE5, 0, 32'h0,
			mk_step(1, 0, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 1, 0),
			NOT_TYPED});
		dir_rows.push_back('{1, VAR_WALKER, 1, 32'h0,
			mk_step(0, 1, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 0, 0),
			NOT_TYPED});
		dir_rows.push_back('{1, VAR_BASE, 0, 32'h0,
			mk_step(1, 1, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 1, 1),
			PENDING_END});

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_variant || dir_rows[i].set_addr) begin
				drain();
				if (dir_rows[i].set_variant) cfg_write(REG_VARIANT, {29'd0, dir_rows[i].variant});
				if (dir_rows[i].set_addr) cfg_write(REG_DATA_ADDR, dir_rows[i].addr);
			end
			send_step(dir_rows[i].step, dir_rows[i].te);
		end

		// finish the bind run the table started, then two whole bind runs,
		// the second one with no sender gaps
		bind_round(VAR_WALKER, $urandom());
		bind_round(VAR_X4, 32'h0000_0000);
		sender_full_rate = 1'b1;
		bind_round(VAR_ZERO_BIND, 32'hFFFF_FFFF);
		sender_full_rate = 1'b0;

		// one ack in bind-check moves the link to data for good;
		// after that every variant code gets a stretch of data steps
		send_step(mk_step(1, 0, pick_stick(), pick_stick(), pick_stick(), pick_stick(), 0, 0),
			NOT_TYPED);
		foreach (DATA_VARIANTS[v]) begin
			drain();
			cfg_write(REG_VARIANT, {29'd0, DATA_VARIANTS[v]});
			cfg_write(REG_DATA_ADDR, $urandom());
			repeat (DATA_STEPS_PER_VARIANT) send_step(random_step(), NOT_TYPED);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (results_due.size() != 0) begin
			$error("%0d expected results never arrived", results_due.size());
			fail_count++;
		end

		$display("covered %0d steps and %0d results: %0d bind and %0d data payloads",
			steps_taken, results_checked, bind_payloads, data_payloads);
		$display("variant codes written %08b, receiver hold-off %0s",
			variants_written, hold_off_done ? "done" : "not reached");
		if (fail_count == 0) begin
			$display("rc_link_bind_and_packet_sequencer_tb OK");
		end else begin
			$display("rc_link_bind_and_packet_sequencer_tb NOT OK");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/rclbs_pkg.sv
rtl/rclbs_front.sv
rtl/rclbs_scale.sv
rtl/rclbs_queue.sv
rtl/rclbs_back.sv
rtl/rc_link_bind_and_packet_sequencer.sv
test/rc_link_bind_and_packet_sequencer_tb.sv
